FILE: rtl/core/ssd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types and constants for the sphere signed distance block.
// ----------------------------------------------------------------------------
package ssd_pkg;

  localparam int COORD_BITS = 24;
  localparam int OUT_BITS   = 24;
  localparam int CFG_BITS   = 48;
  localparam int IDX_BITS   = 3;
  localparam int FAR_SHIFT  = 25;
  localparam int SQ_BITS    = 2 * FAR_SHIFT + 4;
  localparam int LEN_BITS   = SQ_BITS / 2;
  localparam int ROOT_PIPE  = LEN_BITS;

  localparam logic [IDX_BITS-1:0] REG_ROW_X    = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_ROW_Y    = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_ROW_Z    = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_OFFSET_X = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_OFFSET_Y = 3'd4;
  localparam logic [IDX_BITS-1:0] REG_OFFSET_Z = 3'd5;
  localparam logic [IDX_BITS-1:0] REG_RADIUS   = 3'd6;
  localparam logic [IDX_BITS-1:0] REG_INVERTED = 3'd7;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_z;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_x;
  } in_item_t;

  typedef struct packed {
    logic                       saturated;
    logic signed [OUT_BITS-1:0] signed_distance;
  } out_item_t;

endpackage

FILE: rtl/core/ssd_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_lane
// One axis: row dot point, rounding, offset, clamp and square. Three stages.
// ----------------------------------------------------------------------------
module ssd_lane #(
  parameter int COORD_BITS = 24,
  parameter int COEF_BITS  = 16
) (
  input  logic                          clk,
  input  logic [3*COORD_BITS-1:0]       point,
  input  logic [ssd_pkg::CFG_BITS-1:0]  row,
  input  logic signed [31:0]            offset,
  output logic [2*ssd_pkg::FAR_SHIFT:0] square
);

  localparam int FR    = COEF_BITS - 2;
  localparam int PBITS = COORD_BITS + COEF_BITS;
  localparam int ABITS = PBITS + 2;
  localparam int QBITS = ABITS + 2;
  localparam int FBITS = ssd_pkg::FAR_SHIFT + 1;

  logic signed [PBITS-1:0] prod_r [3];
  logic signed [QBITS-1:0] q_r;
  logic [FBITS-1:0]        mag;
  logic [2*ssd_pkg::FAR_SHIFT:0] square_r;
  logic signed [ABITS-1:0] acc;
  logic signed [QBITS-1:0] q_nxt;
  logic [QBITS-1:0]        qa;
  logic [3*COEF_BITS-1:0]  row_w;

  // bits beyond the packed row read as zero
  assign row_w = (3*COEF_BITS)'(row);

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      prod_r[j] <= $signed(row_w[j*COEF_BITS +: COEF_BITS])
                   * $signed(point[j*COORD_BITS +: COORD_BITS]);
    end
    q_r      <= q_nxt;
    square_r <= (2*ssd_pkg::FAR_SHIFT+1)'(mag * mag);
  end

  always_comb begin
    acc = ABITS'(prod_r[0]) + ABITS'(prod_r[1]) + ABITS'(prod_r[2])
          + ABITS'(signed'({1'b0, 1'b1, {(FR-1){1'b0}}}));
    q_nxt = QBITS'(acc >>> FR) + QBITS'(offset);
    qa = q_r[QBITS-1] ? QBITS'(-q_r) : QBITS'(q_r);
    if (qa >= QBITS'(1) << ssd_pkg::FAR_SHIFT) mag = FBITS'(1) << ssd_pkg::FAR_SHIFT;
    else mag = FBITS'(qa);
  end

  assign square = square_r;

endmodule

FILE: rtl/core/ssd_root.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_root
// Pipelined rounded square root, one result bit per stage, with radius,
// sign and saturation as a final stage.
// ----------------------------------------------------------------------------
module ssd_root (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         valid,
  input  logic [ssd_pkg::SQ_BITS-1:0]  sumsq,
  input  logic [23:0]                  radius,
  input  logic                         inverted,
  output logic                         out_valid,
  output ssd_pkg::out_item_t           out_item
);

  localparam int N  = ssd_pkg::ROOT_PIPE;
  localparam int LB = ssd_pkg::LEN_BITS;
  localparam int RB = LB + 2;

  logic [ssd_pkg::SQ_BITS-1:0] x_r [1:N];
  logic [LB-1:0]               r_r [1:N];
  logic [23:0]                 rad_r [1:N];
  logic                        inv_r [1:N];
  logic [N:1]                  v_r;
  logic                        ov_r;
  ssd_pkg::out_item_t          oi_r;
  logic [ssd_pkg::SQ_BITS-1:0] x_in [N];
  logic [LB-1:0]               r_in [N];
  logic [ssd_pkg::SQ_BITS-1:0] x_nxt [N];
  logic [LB-1:0]               r_nxt [N];
  logic [RB+1:0]               rem;
  logic [LB:0]                 len;
  logic signed [LB+2:0]        sd;

  always_comb begin
    x_in[0] = sumsq;
    r_in[0] = '0;
    for (int s = 1; s < N; s++) begin
      x_in[s] = x_r[s];
      r_in[s] = r_r[s];
    end
    for (int s = 0; s < N; s++) begin
      logic [RB-1:0] trial;
      logic [RB-1:0] top;
      trial = {r_in[s], 2'b01};
      top = RB'(x_in[s] >> (2*(N-1-s)));
      x_nxt[s] = x_in[s];
      r_nxt[s] = {r_in[s][LB-2:0], 1'b0};
      if (top >= trial) begin
        x_nxt[s] = x_in[s] - (ssd_pkg::SQ_BITS'(trial) << (2*(N-1-s)));
        r_nxt[s] = {r_in[s][LB-2:0], 1'b1};
      end
    end
    rem = (RB+2)'(x_r[N]);
    len = (LB+1)'(r_r[N]) + ((rem > (RB+2)'(r_r[N])) ? (LB+1)'(1) : '0);
    sd = (LB+3)'(len) - (LB+3)'(rad_r[N]);
    if (inv_r[N]) sd = -sd;
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < N; s++) begin
      x_r[s+1] <= x_nxt[s];
      r_r[s+1] <= r_nxt[s];
    end
    rad_r[1] <= radius;
    inv_r[1] <= inverted;
    for (int s = 1; s < N; s++) begin
      rad_r[s+1] <= rad_r[s];
      inv_r[s+1] <= inv_r[s];
    end
    if (sd > (LB+3)'(signed'(24'sh7fffff))) begin
      oi_r <= '{saturated: 1'b1, signed_distance: 24'sh7fffff};
    end else if (sd < -(LB+3)'(signed'(25'sh0800000))) begin
      oi_r <= '{saturated: 1'b1, signed_distance: 24'sh800000};
    end else begin
      oi_r <= '{saturated: 1'b0, signed_distance: sd[23:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
      ov_r <= 1'b0;
    end else begin
      v_r <= {v_r[N-1:1], valid};
      ov_r <= v_r[N];
    end
  end

  assign out_valid = ov_r;
  assign out_item = oi_r;

`ifndef SYNTHESIS
  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && oi_r.saturated |-> oi_r.signed_distance == 24'sh7fffff
      || oi_r.signed_distance == 24'sh800000) else $error("bad saturation");
  a_valid_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[N] |=> ov_r) else $error("result lost");
  a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[N] |=> !ov_r) else $error("spurious result");
`endif

endmodule

FILE: rtl/core/sphere_signed_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_signed_distance
// Signed distance from a transformed query point to a sphere surface.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_item and raise start; a transfer happens on each edge with
//   start high and busy low. busy is always low, so one point per cycle.
//   Output: out_valid strobes for one cycle with out_item; the receiver must
//   take it then, it cannot stall the block.
//   Config: cfg_we, cfg_index, cfg_data write one register per edge. The user
//   writes only while no points are in flight; the block does not enforce it.
//   Pipeline: 3 lane stages, one merge stage, 27 root stages and one output
//   stage. Throughput: one point per cycle, set by the three parallel axis
//   lanes feeding a fully pipelined square root.
//   Reset: synchronous, active low; registers return to identity transform,
//   zero offsets, radius 4096, not inverted; pipeline valids clear.
// ----------------------------------------------------------------------------
module sphere_signed_distance #(
  parameter int COEF_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  ssd_pkg::in_item_t                   in_item,
  output logic                                out_valid,
  output ssd_pkg::out_item_t                  out_item,
  input  logic                                cfg_we,
  input  logic [ssd_pkg::IDX_BITS-1:0]        cfg_index,
  input  logic [ssd_pkg::CFG_BITS-1:0]        cfg_data
);

  localparam int W = ssd_pkg::CFG_BITS;
  localparam int CB = ssd_pkg::COORD_BITS;

  logic [W-1:0]       row_r [3];
  logic signed [31:0] off_r [3];
  logic [23:0]        radius_r;
  logic               inverted_r;
  logic [2:0]         v_r;
  logic               mv_r;
  logic [ssd_pkg::SQ_BITS-1:0] sum_r;
  logic [2*ssd_pkg::FAR_SHIFT:0] sq [3];
  logic [3*CB-1:0] point;

  assign busy = 1'b0;
  assign point = {in_item.point_z, in_item.point_y, in_item.point_x};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0] <= W'(1) << (COEF_BITS - 2);
      row_r[1] <= W'(1) << (COEF_BITS + COEF_BITS - 2);
      row_r[2] <= W'(1) << (3*COEF_BITS - 2);
      for (int i = 0; i < 3; i++) off_r[i] <= '0;
      radius_r <= 24'd4096;
      inverted_r <= 1'b0;
      v_r <= '0;
      mv_r <= 1'b0;
    end else begin
      v_r <= {v_r[1:0], start};
      mv_r <= v_r[2];
      if (cfg_we) begin
        case (cfg_index)
          ssd_pkg::REG_ROW_X:    row_r[0] <= cfg_data;
          ssd_pkg::REG_ROW_Y:    row_r[1] <= cfg_data;
          ssd_pkg::REG_ROW_Z:    row_r[2] <= cfg_data;
          ssd_pkg::REG_OFFSET_X: off_r[0] <= cfg_data[31:0];
          ssd_pkg::REG_OFFSET_Y: off_r[1] <= cfg_data[31:0];
          ssd_pkg::REG_OFFSET_Z: off_r[2] <= cfg_data[31:0];
          ssd_pkg::REG_RADIUS:   radius_r <= cfg_data[23:0];
          ssd_pkg::REG_INVERTED: inverted_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    ssd_lane #(.COORD_BITS(CB), .COEF_BITS(COEF_BITS)) u_lane (
      .clk(clk), .point(point), .row(row_r[g]), .offset(off_r[g]), .square(sq[g])
    );
  end

  always_ff @(posedge clk) begin
    sum_r <= ssd_pkg::SQ_BITS'(sq[0]) + ssd_pkg::SQ_BITS'(sq[1])
             + ssd_pkg::SQ_BITS'(sq[2]);
  end

  ssd_root u_root (
    .clk(clk), .rst_n(rst_n), .valid(mv_r), .sumsq(sum_r), .radius(radius_r),
    .inverted(inverted_r), .out_valid(out_valid), .out_item(out_item)
  );

`ifndef SYNTHESIS
  a_never_busy: assert property (@(posedge clk) !busy) else $error("busy set");
  a_merge_follows: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[2] |=> mv_r) else $error("merge valid lost");
  a_accept_track: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> v_r[0]) else $error("transfer not tracked");
`endif

endmodule
